// File: hdl/ppts_pkg.sv
`default_nettype none
package ppts_pkg;

  localparam int DEFAULT_TASK_SLOTS = 8;

  localparam logic [1:0] OP_REGISTER = 2'd0;
  localparam logic [1:0] OP_REMOVE   = 2'd1;
  localparam logic [1:0] OP_TICK     = 2'd2;
  localparam logic [1:0] OP_DONE     = 2'd3;

  localparam logic signed [7:0] IDLE_LEVEL = -8'sd128;
  localparam int LATE_LIMIT_SHIFT = 30;
  localparam int LATE_STEP_SHIFT  = 29;
  localparam logic [31:0] LATE_LIMIT = ~((32'd1 << LATE_LIMIT_SHIFT) - 32'd1);
  localparam logic [31:0] LATE_STEP  = 32'd1 << LATE_STEP_SHIFT;

  typedef struct packed {
    logic [1:0]         op;
    logic [2:0]         slot;
    logic signed [7:0]  priority_req;
    logic [30:0]        period;
    logic [31:0]        start_offset;
    logic [31:0]        now;
  } in_item_t;

  typedef struct packed {
    logic               grant_valid;
    logic [2:0]         grant_slot;
    logic signed [7:0]  running_priority;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic apply;
    logic scan_tick;
    logic scan_pick;
    logic advance;
    logic emit;
    logic commit_tick;
    logic commit_done;
  } ctrl_cmd_t;

  typedef struct packed {
    logic tick_ok;
    logic stack_empty;
    logic out_free;
  } dp_status_t;

endpackage
`default_nettype wire

// File: hdl/periodic_priority_task_scheduler_unit.sv
// Flow: a tick that scans steps through the scan state, one slot scanned per cycle, then
// emits; a done on a non-empty stack first advances the top task's schedule, then scans
// and emits; a disabled or full-stack tick and a done on an empty stack go straight to
// emit; register/remove pass through the apply state and give no result. One item at a
// time: a new item is taken only when idle, and emit waits while the output stalls.
// Reset (rst_n, synchronous, active low): disabled, no tasks, empty stack, idle (-128).
`default_nettype none
module periodic_priority_task_scheduler_unit #(
  parameter int TASK_SLOTS = ppts_pkg::DEFAULT_TASK_SLOTS
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire ppts_pkg::in_item_t in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output ppts_pkg::out_item_t     out_data,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic               cfg_data
);
  import ppts_pkg::*;

  localparam int SW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int DW = $clog2(TASK_SLOTS + 1);

  ctrl_cmd_t     cmd;
  dp_status_t    status;
  logic [SW-1:0] scan_idx;

  assign cfg_ready = 1'b1;

  ppts_ctrl #(.TASK_SLOTS(TASK_SLOTS), .SW(SW)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_data.op),
    .status   (status),
    .in_stall (in_stall),
    .cmd      (cmd),
    .scan_idx (scan_idx)
  );

  ppts_dp #(.TASK_SLOTS(TASK_SLOTS), .SW(SW), .DW(DW)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .scan_idx  (scan_idx),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .status    (status)
  );

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("block took no time for an accepted transaction");

  a_grant_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.grant_valid) |-> (out_data.running_priority != IDLE_LEVEL))
    else $error("grant left the running level idle");

  a_no_grant_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.grant_valid) |-> (out_data.grant_slot == 3'd0))
    else $error("slot reported without a grant");

  a_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> status.out_free)
    else $error("result written over a waiting transaction");
`endif

endmodule
`default_nettype wire

// File: hdl/ppts_ctrl.sv
`default_nettype none
module ppts_ctrl #(
  parameter int TASK_SLOTS = 8,
  parameter int SW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic [1:0]        in_op,
  input  wire ppts_pkg::dp_status_t status,
  output logic                   in_stall,
  output ppts_pkg::ctrl_cmd_t    cmd,
  output logic [SW-1:0]          scan_idx
);
  import ppts_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_APPLY, S_ADV, S_SCAN, S_EMIT} state_t;
  typedef enum logic [1:0] {K_NONE, K_TICK, K_DONE} kind_t;

  state_t        state_r, state_nxt;
  kind_t         kind_r, kind_nxt;
  logic [SW-1:0] idx_r, idx_nxt;
  logic          accept;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && (state_r == S_IDLE);
  assign scan_idx = idx_r;

  always_comb begin
    cmd             = '0;
    cmd.load        = accept;
    cmd.apply       = (state_r == S_APPLY);
    cmd.advance     = (state_r == S_ADV);
    cmd.scan_tick   = (state_r == S_SCAN) && (kind_r == K_TICK);
    cmd.scan_pick   = (state_r == S_SCAN) && (kind_r == K_DONE);
    cmd.emit        = (state_r == S_EMIT) && status.out_free;
    cmd.commit_tick = cmd.emit && (kind_r == K_TICK);
    cmd.commit_done = cmd.emit && (kind_r == K_DONE);
  end

  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    idx_nxt   = idx_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          idx_nxt = '0;
          unique case (in_op)
            OP_REGISTER, OP_REMOVE: begin
              state_nxt = S_APPLY;
              kind_nxt  = K_NONE;
            end
            OP_TICK: begin
              state_nxt = status.tick_ok ? S_SCAN : S_EMIT;
              kind_nxt  = status.tick_ok ? K_TICK : K_NONE;
            end
            default: begin
              state_nxt = status.stack_empty ? S_EMIT : S_ADV;
              kind_nxt  = status.stack_empty ? K_NONE : K_DONE;
            end
          endcase
        end
      end
      S_APPLY: state_nxt = S_IDLE;
      S_ADV:   state_nxt = S_SCAN;
      S_SCAN: begin
        idx_nxt = idx_r + 1'b1;
        if (idx_r == SW'(TASK_SLOTS - 1)) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (status.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      kind_r  <= K_NONE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule
`default_nettype wire

// File: hdl/ppts_dp.sv
`default_nettype none
module ppts_dp #(
  parameter int TASK_SLOTS = 8,
  parameter int SW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1,
  parameter int DW = $clog2(TASK_SLOTS + 1)
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire ppts_pkg::in_item_t in_data,
  input  wire ppts_pkg::ctrl_cmd_t cmd,
  input  wire logic [SW-1:0]      scan_idx,
  input  wire logic               cfg_valid,
  input  wire logic               cfg_data,
  input  wire logic               out_stall,
  output logic                    out_valid,
  output ppts_pkg::out_item_t     out_data,
  output ppts_pkg::dp_status_t    status
);
  import ppts_pkg::*;

  in_item_t              it_r;
  logic                  enable_r;
  logic [TASK_SLOTS-1:0] valid_r, started_r;
  logic signed [7:0]     prio_r     [TASK_SLOTS];
  logic [30:0]           period_r   [TASK_SLOTS];
  logic [31:0]           anchor_r   [TASK_SLOTS];
  logic [31:0]           due_r      [TASK_SLOTS];
  logic [31:0]           lateness_r [TASK_SLOTS];
  logic [TASK_SLOTS-1:0] older_r    [TASK_SLOTS];
  logic [TASK_SLOTS-1:0] pend_r     [TASK_SLOTS];
  logic signed [7:0]     saved_r    [TASK_SLOTS];
  logic [SW-1:0]         rslot_r    [TASK_SLOTS];
  logic [DW-1:0]         depth_r;
  logic signed [7:0]     level_r;

  logic                  best_valid_r;
  logic [SW-1:0]         best_slot_r;
  logic signed [7:0]     best_prio_r;
  logic [31:0]           best_lat_r;
  logic [TASK_SLOTS-1:0] mask_r;

  logic                  out_valid_r;
  out_item_t             out_data_r;

  logic [SW-1:0]         sidx, top, push, rs;
  logic                  sidx_ok;
  logic [31:0]           due_eff, lat_new, lat_use;
  logic                  cand, in_mask, better;

  assign sidx    = SW'(it_r.slot);
  assign sidx_ok = (32'(it_r.slot) < TASK_SLOTS);
  assign top     = SW'(depth_r - 1'b1);
  assign push    = SW'(depth_r);
  assign rs      = rslot_r[top];

  assign due_eff = started_r[scan_idx] ? due_r[scan_idx] : (it_r.now + anchor_r[scan_idx]);
  assign lat_new = due_eff - it_r.now;

  always_comb begin
    if (cmd.scan_tick) begin
      cand    = valid_r[scan_idx] && (prio_r[scan_idx] > level_r);
      lat_use = lat_new;
      in_mask = cand && ($signed(lat_new) <= 32'sd0);
    end else begin
      cand    = pend_r[top][scan_idx];
      lat_use = lateness_r[scan_idx];
      in_mask = cand;
    end
    better = in_mask && (!best_valid_r || (prio_r[scan_idx] > best_prio_r) ||
             ((prio_r[scan_idx] == best_prio_r) &&
              (($signed(lat_use) < $signed(best_lat_r)) ||
               ((lat_use == best_lat_r) && older_r[scan_idx][best_slot_r]))));
  end

  assign status.tick_ok     = enable_r && (32'(depth_r) < TASK_SLOTS);
  assign status.stack_empty = (depth_r == '0);
  assign status.out_free    = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r    <= 1'b0;
      valid_r     <= '0;
      started_r   <= '0;
      depth_r     <= '0;
      level_r     <= IDLE_LEVEL;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        enable_r <= cfg_data;
      end
      if (cmd.apply && sidx_ok) begin
        valid_r[sidx]   <= (it_r.op == OP_REGISTER);
        started_r[sidx] <= 1'b0;
      end
      if (cmd.scan_tick && cand && !started_r[scan_idx]) begin
        started_r[scan_idx] <= 1'b1;
      end
      if (cmd.commit_tick && best_valid_r) begin
        depth_r <= depth_r + 1'b1;
        level_r <= best_prio_r;
      end
      if (cmd.commit_done) begin
        if (best_valid_r) begin
          level_r <= best_prio_r;
        end else begin
          level_r <= saved_r[top];
          depth_r <= depth_r - 1'b1;
        end
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      it_r         <= in_data;
      best_valid_r <= 1'b0;
      mask_r       <= '0;
    end
    if (cmd.apply && sidx_ok) begin
      if (valid_r[sidx]) begin
        for (int d = 0; d < TASK_SLOTS; d++) begin
          pend_r[d][sidx] <= 1'b0;
        end
      end
      if (it_r.op == OP_REGISTER) begin
        prio_r[sidx]   <= it_r.priority_req;
        period_r[sidx] <= it_r.period;
        anchor_r[sidx] <= it_r.start_offset;
        // newest registration ranks after every other slot
        for (int j = 0; j < TASK_SLOTS; j++) begin
          for (int k = 0; k < TASK_SLOTS; k++) begin
            if (SW'(j) == sidx) begin
              older_r[j][k] <= 1'b0;
            end else if (SW'(k) == sidx) begin
              older_r[j][k] <= 1'b1;
            end
          end
        end
      end
    end
    if (cmd.scan_tick && cand) begin
      if (!started_r[scan_idx]) begin
        anchor_r[scan_idx] <= due_eff;
      end
      lateness_r[scan_idx] <= lat_new;
      due_r[scan_idx] <= ((lat_new ^ 32'h8000_0000) < (32'h8000_0000 ^ LATE_LIMIT)) ?
                         (due_eff + LATE_STEP) : due_eff;
      if (in_mask) begin
        mask_r[scan_idx] <= 1'b1;
      end
    end
    if ((cmd.scan_tick || cmd.scan_pick) && better) begin
      best_valid_r <= 1'b1;
      best_slot_r  <= scan_idx;
      best_prio_r  <= prio_r[scan_idx];
      best_lat_r   <= lat_use;
    end
    if (cmd.advance && valid_r[rs] && started_r[rs]) begin
      due_r[rs]    <= anchor_r[rs] + {1'b0, period_r[rs]};
      anchor_r[rs] <= anchor_r[rs] + {1'b0, period_r[rs]};
    end
    if (cmd.commit_tick && best_valid_r) begin
      pend_r[push]  <= mask_r & ~(TASK_SLOTS'(1) << best_slot_r);
      saved_r[push] <= level_r;
      rslot_r[push] <= best_slot_r;
    end
    if (cmd.commit_done && best_valid_r) begin
      pend_r[top][best_slot_r] <= 1'b0;
      rslot_r[top]             <= best_slot_r;
    end
    if (cmd.emit) begin
      out_data_r.grant_valid <= best_valid_r && (cmd.commit_tick || cmd.commit_done);
      out_data_r.grant_slot  <= (best_valid_r && (cmd.commit_tick || cmd.commit_done)) ?
                                3'(best_slot_r) : 3'd0;
      if ((cmd.commit_tick || cmd.commit_done) && best_valid_r) begin
        out_data_r.running_priority <= best_prio_r;
      end else if (cmd.commit_done) begin
        out_data_r.running_priority <= saved_r[top];
      end else begin
        out_data_r.running_priority <= level_r;
      end
    end
  end

endmodule
`default_nettype wire
